/* src/smsd_pkg.sv */
// Shared constants and control types of the sliding median spike detector.
package smsd_pkg;

  localparam int VALUE_RANGE_DEF = 256;
  localparam int WINDOW_MAX_DEF  = 256;
  localparam int SAMPLE_W        = 8;
  localparam int LEN_W           = 9;
  localparam int DMED_W          = 9;
  localparam int COUNT_W         = 32;
  localparam int TDATA_W         = 48;

  // Control flags that travel with the median wavefront from cell to cell.
  typedef struct packed {
    logic valid;
    logic lo_found;
    logic hi_found;
  } wave_ctl_t;

  // Histogram update command broadcast to every cell.
  typedef struct packed {
    logic clear;
    logic inc_en;
    logic dec_en;
  } hist_upd_t;

endpackage

/* src/sliding_median_spike_detector_top.sv */
// Top level of the sliding median spike detector: control, sample ring and cell row.
//
// Each sample is compared against twice the median of the preceding window of
// window_length samples (sum of the two middle values for an even window); a
// sample at or above it raises the spike flag and bumps a saturating count.
// The histogram is a row of VALUE_RANGE cells, and the median is found by a
// wavefront that carries the running count through one cell per clock. A
// sample that arrives while the window is still filling goes from accept
// straight to the FINISH state, which registers its result onto the output.
// Once the window is full, the sample waits in WALK while the wavefront
// walks the cell row; the doubled median is then registered and the item
// moves to FINISH. One sample is in work at a time, and the next beat is
// taken while a result waits on the output; a finished item stalls only
// while that earlier result is still unclaimed. Writing window_length
// empties the window and keeps the spike count; there is no clearing pass
// after reset.
module sliding_median_spike_detector_top #(
  parameter int VALUE_RANGE = smsd_pkg::VALUE_RANGE_DEF,
  parameter int WINDOW_MAX  = smsd_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [smsd_pkg::LEN_W-1:0]    cfg_wr_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] sample_value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [smsd_pkg::TDATA_W-1:0]  m_axis_tdata,  // [8:0] doubled_median,
                                                       // [9] spike_flag,
                                                       // [41:10] spike_count, rest zero
  output logic                          m_axis_tuser   // [0] window_full
);
  import smsd_pkg::*;

  localparam int VAL_W   = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int RING_AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_CW  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int SAT_W   = (VAL_W > SAMPLE_W) ? VAL_W : SAMPLE_W;
  localparam int PAD_W   = TDATA_W - DMED_W - 1 - COUNT_W;

  typedef enum logic [1:0] {IDLE, WALK, FINISH} state_t;

  state_t               state;
  logic [LEN_W-1:0]     window_length;
  logic [RING_AW-1:0]   pos;
  logic [CNT_W-1:0]     fill;
  logic [COUNT_W-1:0]   flag_total;
  logic [SAMPLE_W-1:0]  sample_reg;
  logic                 full_reg;
  logic [DMED_W-1:0]    dmed_reg;

  logic [LEN_CW-1:0]    wl_ext;
  logic [CNT_W-1:0]     eff_len;
  logic [CNT_W-1:0]     half_len;
  logic [CNT_W-1:0]     r_lo;
  logic [CNT_W-1:0]     r_hi;
  logic                 accept;
  logic                 full_now;
  logic                 finish_go;
  logic [SAT_W-1:0]     s_ext;
  logic [SAMPLE_W-1:0]  s_sat;
  logic [CNT_W-1:0]     pos_plus;
  logic [RING_AW-1:0]   pos_next;
  logic                 flag;
  logic [COUNT_W-1:0]   flag_total_next;
  logic [SAMPLE_W-1:0]  ring_rd;
  logic [VAL_W-1:0]     inc_val;
  logic [VAL_W-1:0]     dec_val;
  logic [VAL_W:0]       med_sum;
  hist_upd_t            upd;

  wave_ctl_t            ctl_chain [VALUE_RANGE + 1];
  logic [CNT_W-1:0]     sum_chain [VALUE_RANGE + 1];
  logic [VAL_W-1:0]     lo_chain  [VALUE_RANGE + 1];
  logic [VAL_W-1:0]     hi_chain  [VALUE_RANGE + 1];

  // A length of zero acts as one, and a length beyond the ring acts as the ring size.
  always_comb begin
    wl_ext = LEN_CW'(window_length);
    if (wl_ext == '0) begin
      eff_len = CNT_W'(1);
    end else if (wl_ext > LEN_CW'(WINDOW_MAX)) begin
      eff_len = CNT_W'(WINDOW_MAX);
    end else begin
      eff_len = CNT_W'(wl_ext);
    end
    half_len = eff_len >> 1;
    r_hi     = half_len;
    r_lo     = eff_len[0] ? half_len : half_len - CNT_W'(1);
  end

  always_comb begin
    s_ext = SAT_W'(s_axis_tdata);
    if (s_ext > SAT_W'(VALUE_RANGE - 1)) begin
      s_ext = SAT_W'(VALUE_RANGE - 1);
    end
    s_sat = SAMPLE_W'(s_ext);
  end

  assign s_axis_tready   = (state == IDLE);
  assign accept          = s_axis_tvalid && s_axis_tready;
  assign full_now        = (fill >= eff_len);
  assign finish_go       = (state == FINISH) && (!m_axis_tvalid || m_axis_tready);
  assign flag            = full_reg && ({1'b0, sample_reg} >= dmed_reg);
  assign flag_total_next = (flag && (flag_total != '1)) ?
                           flag_total + COUNT_W'(1) : flag_total;
  assign pos_plus        = CNT_W'(pos) + CNT_W'(1);
  assign pos_next        = (pos_plus >= eff_len) ? '0 : RING_AW'(pos_plus);
  assign inc_val         = VAL_W'(SAT_W'(sample_reg));
  assign dec_val         = VAL_W'(SAT_W'(ring_rd));
  assign med_sum         = {1'b0, lo_chain[VALUE_RANGE]} + {1'b0, hi_chain[VALUE_RANGE]};

  always_comb begin
    upd.clear  = cfg_wr_en;
    upd.inc_en = finish_go;
    upd.dec_en = finish_go && full_reg;
  end

  // The oldest sample is read at accept; its slot is overwritten when the item finishes.
  smsd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk     (clk),
    .wr_en   (finish_go),
    .wr_addr (pos),
    .wr_data (sample_reg),
    .rd_en   (accept),
    .rd_addr (pos),
    .rd_data (ring_rd)
  );

  always_comb begin
    ctl_chain[0].valid    = accept && full_now;
    ctl_chain[0].lo_found = 1'b0;
    ctl_chain[0].hi_found = 1'b0;
    sum_chain[0]          = '0;
    lo_chain[0]           = '0;
    hi_chain[0]           = '0;
  end

  for (genvar i = 0; i < VALUE_RANGE; i++) begin : g_cell
    smsd_cell #(
      .CNT_W (CNT_W),
      .VAL_W (VAL_W),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .upd     (upd),
      .inc_val (inc_val),
      .dec_val (dec_val),
      .r_lo    (r_lo),
      .r_hi    (r_hi),
      .ctl_in  (ctl_chain[i]),
      .sum_in  (sum_chain[i]),
      .lo_in   (lo_chain[i]),
      .hi_in   (hi_chain[i]),
      .ctl_out (ctl_chain[i + 1]),
      .sum_out (sum_chain[i + 1]),
      .lo_out  (lo_chain[i + 1]),
      .hi_out  (hi_chain[i + 1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      window_length <= LEN_W'(1);
      pos           <= '0;
      fill          <= '0;
      flag_total    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // A new result may replace one that is taken in the same cycle.
      if (finish_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
        pos           <= '0;
        fill          <= '0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            sample_reg <= s_sat;
            full_reg   <= full_now;
            dmed_reg   <= '0;
            state      <= full_now ? WALK : FINISH;
          end
        end
        WALK: begin
          if (ctl_chain[VALUE_RANGE].valid) begin
            dmed_reg <= DMED_W'(med_sum);
            state    <= FINISH;
          end
        end
        FINISH: begin
          if (finish_go) begin
            pos <= pos_next;
            if (!full_reg) begin
              fill <= fill + CNT_W'(1);
            end
            flag_total   <= flag_total_next;
            m_axis_tuser <= full_reg;
            m_axis_tdata <= {{PAD_W{1'b0}}, flag_total_next, flag, dmed_reg};
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= eff_len)
    else $error("fill level exceeds the window length");

  a_wave_in_walk: assert property (@(posedge clk) disable iff (rst)
    ctl_chain[VALUE_RANGE].valid |-> (state == WALK))
    else $error("median wavefront arrived outside the walk");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == FINISH))
    else $error("result beat raised without finishing an item");

  a_no_median_unfilled: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[9:0] == '0))
    else $error("median or flag reported before the window filled");
`endif

endmodule

/* src/smsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module smsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/smsd_cell.sv */
// One histogram bin: holds its count and adds it to the passing median wavefront.
module smsd_cell #(
  parameter int CNT_W = 9,
  parameter int VAL_W = 8,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  smsd_pkg::hist_upd_t      upd,
  input  logic [VAL_W-1:0]         inc_val,
  input  logic [VAL_W-1:0]         dec_val,
  input  logic [CNT_W-1:0]         r_lo,
  input  logic [CNT_W-1:0]         r_hi,
  input  smsd_pkg::wave_ctl_t      ctl_in,
  input  logic [CNT_W-1:0]         sum_in,
  input  logic [VAL_W-1:0]         lo_in,
  input  logic [VAL_W-1:0]         hi_in,
  output smsd_pkg::wave_ctl_t      ctl_out,
  output logic [CNT_W-1:0]         sum_out,
  output logic [VAL_W-1:0]         lo_out,
  output logic [VAL_W-1:0]         hi_out
);
  import smsd_pkg::*;

  localparam logic [VAL_W-1:0] MY_VAL = VAL_W'(INDEX);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] sum_new;
  logic             lo_hit;
  logic             hi_hit;
  logic             do_inc;
  logic             do_dec;

  // Increment and decrement apply together; the decrement is taken only from a nonzero bin.
  always_comb begin
    do_inc   = upd.inc_en && (inc_val == MY_VAL);
    do_dec   = upd.dec_en && (dec_val == MY_VAL) && (cnt != '0);
    cnt_next = cnt + CNT_W'(do_inc) - CNT_W'(do_dec);
  end

  always_comb begin
    sum_new = sum_in + cnt;
    lo_hit  = !ctl_in.lo_found && (sum_new > r_lo);
    hi_hit  = !ctl_in.hi_found && (sum_new > r_hi);
  end

  always_ff @(posedge clk) begin
    if (rst || upd.clear) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out.valid    <= ctl_in.valid;
      ctl_out.lo_found <= ctl_in.lo_found || lo_hit;
      ctl_out.hi_found <= ctl_in.hi_found || hi_hit;
    end
    sum_out <= sum_new;
    lo_out  <= lo_hit ? MY_VAL : lo_in;
    hi_out  <= hi_hit ? MY_VAL : hi_in;
  end

endmodule
